[hdl/irpwc_pkg.sv]
// Package for the IR pulse width capture block: phase codes, register map,
// result record and parameter defaults. No dependencies.
`default_nettype none

package irpwc_pkg;

  // Parameter defaults
  localparam int BUFFER_DEPTH_DEF = 128;
  localparam int TICK_WIDTH_DEF   = 16;

  // Field widths fixed by the interface
  localparam int GAP_W      = 16;
  localparam int DUR_W      = 16;
  localparam int IDX_W      = 7;
  localparam int CNT_OUT_W  = 8;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic REG_IDLE_GAP   = 1'b0;
  localparam logic REG_MARK_LEVEL = 1'b1;

  localparam logic [GAP_W-1:0] IDLE_GAP_RST = 16'd100;
  localparam logic MARK_LEVEL_RST = 1'b0;

  // Input kinds
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_MARK  = 2'd1,
    PH_SPACE = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] record_count;
    logic                 overflowed;
    logic                 frame_done;
    phase_t               receiver_phase;
    logic [DUR_W-1:0]     duration;
    logic [IDX_W-1:0]     record_index;
    logic                 recorded;
  } result_t;

endpackage : irpwc_pkg

`default_nettype wire

[hdl/irpwc_core.sv]
// Capture state and per-tick update for the IR pulse width capture block.
// Depends on irpwc_pkg for phase codes and the result record.
`default_nettype none

module irpwc_core #(
  parameter int BUFFER_DEPTH = irpwc_pkg::BUFFER_DEPTH_DEF,
  parameter int TICK_WIDTH   = irpwc_pkg::TICK_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step_en,
  input  wire logic                       kind,
  input  wire logic                       pin_level,
  input  wire logic [irpwc_pkg::GAP_W-1:0] idle_gap,
  input  wire logic                       mark_level,
  output irpwc_pkg::result_t              result
);

  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int CMP_W = (TICK_WIDTH > irpwc_pkg::GAP_W) ? TICK_WIDTH : irpwc_pkg::GAP_W;

  irpwc_pkg::phase_t     phase_r, phase_nxt;
  logic [TICK_WIDTH-1:0] tick_r, tick_nxt, tick_inc;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  ovf_r, ovf_nxt;

  logic                  is_mark, full, tick_ge_gap, tick_gt_gap, restart;
  logic                  rec;
  logic [CNT_W-1:0]      rec_idx;
  logic [TICK_WIDTH-1:0] dur;
  logic [31:0]           idx_ext, dur_ext, cnt_ext;

  assign restart     = (kind == irpwc_pkg::KIND_RESTART);
  assign is_mark     = (pin_level == mark_level);
  assign tick_inc    = tick_r + TICK_WIDTH'(1);
  assign full        = (cnt_r >= CNT_W'(BUFFER_DEPTH));
  assign tick_ge_gap = (CMP_W'(tick_inc) >= CMP_W'(idle_gap));
  assign tick_gt_gap = (CMP_W'(tick_inc) >  CMP_W'(idle_gap));

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (restart) begin
      phase_nxt = irpwc_pkg::PH_IDLE;
    end else if (full) begin
      phase_nxt = irpwc_pkg::PH_STOP;
    end else begin
      case (phase_r)
        irpwc_pkg::PH_IDLE: begin
          if (is_mark && tick_ge_gap) phase_nxt = irpwc_pkg::PH_MARK;
        end
        irpwc_pkg::PH_MARK: begin
          if (!is_mark) phase_nxt = irpwc_pkg::PH_SPACE;
        end
        irpwc_pkg::PH_SPACE: begin
          if (is_mark) phase_nxt = irpwc_pkg::PH_MARK;
          else if (tick_gt_gap) phase_nxt = irpwc_pkg::PH_STOP;
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Counters, flags and the emitted duration
  always_comb begin
    tick_nxt = tick_inc;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    rec      = 1'b0;
    rec_idx  = '0;
    dur      = '0;
    if (restart) begin
      tick_nxt = '0;
      cnt_nxt  = '0;
      ovf_nxt  = 1'b0;
    end else if (full) begin
      ovf_nxt = 1'b1;
    end else begin
      case (phase_r)
        irpwc_pkg::PH_IDLE: begin
          if (is_mark) begin
            tick_nxt = '0;
            if (tick_ge_gap) begin
              ovf_nxt = 1'b0;
              rec     = 1'b1;
              dur     = tick_inc;
              cnt_nxt = CNT_W'(1);
            end
          end
        end
        irpwc_pkg::PH_MARK, irpwc_pkg::PH_SPACE: begin
          // an edge closes the running duration
          if (is_mark == (phase_r == irpwc_pkg::PH_SPACE)) begin
            rec      = 1'b1;
            rec_idx  = cnt_r;
            dur      = tick_inc;
            cnt_nxt  = cnt_r + CNT_W'(1);
            tick_nxt = '0;
          end
        end
        default: begin
          if (is_mark) tick_nxt = '0;
        end
      endcase
    end
  end

  assign idx_ext = 32'(rec_idx);
  assign dur_ext = 32'(dur);
  assign cnt_ext = 32'(cnt_nxt);

  always_comb begin
    result.recorded       = rec;
    result.record_index   = idx_ext[irpwc_pkg::IDX_W-1:0];
    result.duration       = dur_ext[irpwc_pkg::DUR_W-1:0];
    result.receiver_phase = phase_nxt;
    result.frame_done     = (phase_nxt == irpwc_pkg::PH_STOP);
    result.overflowed     = ovf_nxt;
    result.record_count   = cnt_ext[irpwc_pkg::CNT_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= irpwc_pkg::PH_IDLE;
      tick_r  <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule : irpwc_core

`default_nettype wire

[hdl/ir_pulse_width_capture.sv]
// Top level of the IR pulse width capture block: stream ports, APB register
// port and a two-entry output stage. Depends on irpwc_pkg and irpwc_core.
`default_nettype none

// One item is taken per clock while in_tready is high: each sampling tick
// updates the tick counter, compares it with the idle gap threshold and moves
// the capture phase; its result is registered in the output register or the
// skid entry. A restart item clears the capture state to idle and returns a
// zero result. The output register is backed by a skid entry, so one further
// item is taken while a result waits; in_tready falls only when both entries
// are full. The idle gap threshold lies at byte address 0, mark_level at byte
// address 4; write them only while the block is idle.
module ir_pulse_width_capture #(
  parameter int BUFFER_DEPTH = irpwc_pkg::BUFFER_DEPTH_DEF,
  parameter int TICK_WIDTH   = irpwc_pkg::TICK_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [irpwc_pkg::IN_TDATA_W-1:0]    in_tdata,  // [0] pin_level
  input  wire logic                                in_tuser,  // [0] kind
  // result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [0] recorded, [7:1] record_index, [23:8] duration, [25:24] receiver_phase,
  // [26] frame_done, [27] overflowed, [35:28] record_count
  output logic [irpwc_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // configuration
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [irpwc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [irpwc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [irpwc_pkg::CFG_DATA_W-1:0]         cfg_prdata,
  output logic                                     cfg_pready
);

  localparam int RES_W = $bits(irpwc_pkg::result_t);

  logic [irpwc_pkg::GAP_W-1:0] idle_gap_r;
  logic                        mark_level_r;
  logic                        cfg_wr;
  logic                        reg_sel;

  irpwc_pkg::result_t step_res;
  irpwc_pkg::result_t out_res_r, skid_res_r;
  logic               out_vld_r, skid_vld_r;
  logic               acc_in, acc_out, load_out;

  // Register port
  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_gap_r   <= irpwc_pkg::IDLE_GAP_RST;
      mark_level_r <= irpwc_pkg::MARK_LEVEL_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        irpwc_pkg::REG_IDLE_GAP:   idle_gap_r   <= cfg_pwdata[irpwc_pkg::GAP_W-1:0];
        irpwc_pkg::REG_MARK_LEVEL: mark_level_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      irpwc_pkg::REG_IDLE_GAP:   cfg_prdata = irpwc_pkg::CFG_DATA_W'(idle_gap_r);
      irpwc_pkg::REG_MARK_LEVEL: cfg_prdata = irpwc_pkg::CFG_DATA_W'(mark_level_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // Handshakes
  assign in_tready = !skid_vld_r;
  assign acc_in    = in_tvalid && in_tready;
  assign acc_out   = out_vld_r && out_tready;
  assign load_out  = !out_vld_r || acc_out;

  irpwc_core #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .TICK_WIDTH   (TICK_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (acc_in),
    .kind       (in_tuser),
    .pin_level  (in_tdata[0]),
    .idle_gap   (idle_gap_r),
    .mark_level (mark_level_r),
    .result     (step_res)
  );

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (load_out) begin
      out_vld_r  <= skid_vld_r || acc_in;
      skid_vld_r <= 1'b0;
    end else if (acc_in) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_r <= skid_vld_r ? skid_res_r : step_res;
    end
    // hold the new item aside while the output register is stalled
    if (!load_out && acc_in) begin
      skid_res_r <= step_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = irpwc_pkg::OUT_TDATA_W'(RES_W'(out_res_r));

endmodule : ir_pulse_width_capture

`default_nettype wire
